// File: design/peer_table_lru_replacement_macros.svh
// Assertion macros used by the peer table top level.
`ifndef PEER_TABLE_LRU_REPLACEMENT_MACROS_SVH
`define PEER_TABLE_LRU_REPLACEMENT_MACROS_SVH
`ifndef SYNTHESIS
`define PTLRU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("peer table assertion failed");
`define PTLRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("peer table assertion failed");
`else
`define PTLRU_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PTLRU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/ptlru_pkg.sv
// Types and codes shared by the peer table modules.
package ptlru_pkg;

    localparam logic [2:0] CMD_LOOKUP  = 3'd0;
    localparam logic [2:0] CMD_TOUCH   = 3'd1;
    localparam logic [2:0] CMD_SET_REG = 3'd2;
    localparam logic [2:0] CMD_SET_PIN = 3'd3;
    localparam logic [2:0] CMD_REMOVE  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BADARG   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [47:0] addr;
        logic [31:0] time_stamp;
        logic        registered;
        logic        pinned;
    } t_entry;

    typedef struct packed {
        logic rot;
        logic wr;
        logic rm;
    } t_cell_ctl;

endpackage

// File: design/ptlru_cell.sv
// One table slot: rotates to its neighbor, takes a write, or shifts down on removal.
module ptlru_cell #(
    parameter int IDX = 0,
    parameter int IW  = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptlru_pkg::t_cell_ctl i_ctl,
    input  logic [IW-1:0]       i_pos,
    input  ptlru_pkg::t_entry   i_wdata,
    input  ptlru_pkg::t_entry   i_next,
    output ptlru_pkg::t_entry   o_entry
);

    ptlru_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_ctl.rot) begin
            r_entry <= i_next;
        end else if (i_ctl.wr && (i_pos == IW'(IDX))) begin
            r_entry <= i_wdata;
        end else if (i_ctl.rm && (i_pos <= IW'(IDX))) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

// File: design/peer_table_lru_replacement.sv
// Peer table top level: scan controller, result register and the row of slot cells.
// An input transfer starts a scan that rotates every slot past cell 0; the command is then
// applied and its result registered. No new item is taken until the block is idle again.
// The result register frees the input side, but an item waits in its last step while
// an earlier result is still stalled.
// Reset (synchronous, active low) empties the table and clears every slot at once.
`include "peer_table_lru_replacement_macros.svh"
module peer_table_lru_replacement #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [47:0] i_peer_address,
    input  logic [31:0] i_now_time,
    input  logic        i_flag_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [3:0]  o_entry_index,
    output logic        o_is_registered,
    output logic        o_is_pinned,
    output logic [31:0] o_last_used
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int KW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]        r_state;
    logic [2:0]        r_cmd;
    logic [47:0]       r_addr;
    logic [31:0]       r_now;
    logic              r_flag;
    logic [KW-1:0]     r_k;
    logic [KW-1:0]     r_count;
    logic              r_found;
    logic [IW-1:0]     r_fpos;
    ptlru_pkg::t_entry r_fent;
    logic              r_vfound;
    logic [IW-1:0]     r_vpos;
    logic [31:0]       r_vtime;

    logic              r_out_valid;
    logic [1:0]        r_status;
    logic [3:0]        r_index;
    logic              r_reg;
    logic              r_pin;
    logic [31:0]       r_time;

    ptlru_pkg::t_entry   w_ent [CAPACITY];
    ptlru_pkg::t_entry   w_next [CAPACITY];
    ptlru_pkg::t_cell_ctl w_ctl;
    logic [IW-1:0]       w_pos;
    ptlru_pkg::t_entry   w_wdata;
    logic                w_done;
    logic                w_hit;
    logic                w_older;
    logic [KW-1:0]       n_count;
    logic [1:0]          n_status;
    logic [IW-1:0]       n_opos;
    logic                n_reg;
    logic                n_pin;
    logic [31:0]         n_time;

    logic w_in_xfer;
    assign w_in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_done     = (r_state == S_APPLY) && (!r_out_valid || !i_out_stall);

    // Cell 0 shows table position r_k during the scan.
    assign w_hit   = (r_k < r_count) && (r_addr != '0) && (w_ent[0].addr == r_addr);
    assign w_older = (r_k < r_count) && !w_ent[0].pinned
                     && (!r_vfound || (w_ent[0].time_stamp < r_vtime));

    always_comb begin
        w_ctl    = '0;
        w_ctl.rot = (r_state == S_SCAN);
        w_pos    = r_fpos;
        w_wdata  = r_fent;
        n_count  = r_count;
        n_status = ptlru_pkg::ST_OK;
        n_opos   = r_fpos;
        n_reg    = r_fent.registered;
        n_pin    = r_fent.pinned;
        n_time   = r_fent.time_stamp;
        if (r_cmd == ptlru_pkg::CMD_TOUCH) begin
            w_wdata.addr       = r_addr;
            w_wdata.time_stamp = r_now;
            n_time             = r_now;
            if (r_addr == '0) begin
                n_status = ptlru_pkg::ST_BADARG;
            end else if (r_found) begin
                w_ctl.wr = 1'b1;
            end else begin
                w_wdata.registered = 1'b0;
                w_wdata.pinned     = 1'b0;
                n_reg              = 1'b0;
                n_pin              = 1'b0;
                if (r_count < KW'(CAPACITY)) begin
                    w_ctl.wr = 1'b1;
                    w_pos    = IW'(r_count);
                    n_opos   = IW'(r_count);
                    n_count  = r_count + 1'b1;
                end else if (r_vfound) begin
                    w_ctl.wr = 1'b1;
                    w_pos    = r_vpos;
                    n_opos   = r_vpos;
                end else begin
                    n_status = ptlru_pkg::ST_FULL;
                end
            end
        end else if (!r_found) begin
            n_status = ptlru_pkg::ST_NOTFOUND;
        end else if (r_cmd == ptlru_pkg::CMD_SET_REG) begin
            w_ctl.wr           = 1'b1;
            w_wdata.registered = r_flag;
            n_reg              = r_flag;
        end else if (r_cmd == ptlru_pkg::CMD_SET_PIN) begin
            w_ctl.wr       = 1'b1;
            w_wdata.pinned = r_flag;
            n_pin          = r_flag;
        end else if (r_cmd == ptlru_pkg::CMD_REMOVE) begin
            w_ctl.rm = 1'b1;
            n_count  = r_count - 1'b1;
            n_reg    = 1'b0;
            n_pin    = 1'b0;
            n_time   = '0;
        end
        if (n_status != ptlru_pkg::ST_OK) begin
            n_opos = '0;
            n_reg  = 1'b0;
            n_pin  = 1'b0;
            n_time = '0;
        end
        if (!w_done) begin
            w_ctl.wr = 1'b0;
            w_ctl.rm = 1'b0;
            n_count  = r_count;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == CAPACITY - 1) begin : g_last
                assign w_next[g] = w_ctl.rot ? w_ent[0] : '0;
            end else begin : g_mid
                assign w_next[g] = w_ent[g+1];
            end
            ptlru_cell #(.IDX(g), .IW(IW)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_pos   (w_pos),
                .i_wdata (w_wdata),
                .i_next  (w_next[g]),
                .o_entry (w_ent[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_k         <= '0;
            r_found     <= 1'b0;
            r_vfound    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_state  <= S_SCAN;
                        r_k      <= '0;
                        r_found  <= 1'b0;
                        r_vfound <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_k <= r_k + 1'b1;
                    if (w_hit && !r_found) begin
                        r_found <= 1'b1;
                    end
                    if (w_older) begin
                        r_vfound <= 1'b1;
                    end
                    if (r_k == KW'(CAPACITY - 1)) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (w_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_cmd  <= i_cmd;
            r_addr <= i_peer_address;
            r_now  <= i_now_time;
            r_flag <= i_flag_value;
        end
        if ((r_state == S_SCAN) && w_hit && !r_found) begin
            r_fpos <= IW'(r_k);
            r_fent <= w_ent[0];
        end
        if ((r_state == S_SCAN) && w_older) begin
            r_vpos  <= IW'(r_k);
            r_vtime <= w_ent[0].time_stamp;
        end
        if (w_done) begin
            r_status <= n_status;
            r_index  <= 4'(n_opos);
            r_reg    <= n_reg;
            r_pin    <= n_pin;
            r_time   <= n_time;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_entry_index   = r_index;
    assign o_is_registered = r_reg;
    assign o_is_pinned     = r_pin;
    assign o_last_used     = r_time;

    `PTLRU_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= KW'(CAPACITY))
    `PTLRU_ASSERT_NEXT(a_xfer_scan, i_clk, i_rst_n, w_in_xfer, r_state == S_SCAN)
    `PTLRU_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, r_state != S_APPLY, $stable(r_count))
    `PTLRU_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, w_done, o_out_valid)

endmodule

// File: tb/sv/peer_table_lru_replacement_test.sv
// Testbench for the peer table: queued driver, monitor and a behavioral table predictor.
`timescale 1ns / 100ps
module peer_table_lru_replacement_test;

    localparam int SLOTS = 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [47:0] addr;
        logic [31:0] now;
        logic        flag;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  index;
        logic        registered;
        logic        pinned;
        logic [31:0] last_used;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_cmd = '0;
    logic [47:0] i_peer_address = '0;
    logic [31:0] i_now_time = '0;
    logic        i_flag_value = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [3:0]  o_entry_index;
    logic        o_is_registered;
    logic        o_is_pinned;
    logic [31:0] o_last_used;

    peer_table_lru_replacement #(.CAPACITY(SLOTS)) DUT (.*);

    always #5 i_clk = ~i_clk;

    t_request pending_requests[$];
    t_answer  expected_answers[$];
    ptlru_pkg::t_entry table_rows[SLOTS];
    int       row_count = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       error_count = 0;
    int       answers_checked = 0;
    int       cycle_count = 0;
    bit       hold_sender = 1'b0;
    bit       in_done = 1'b0;
    logic [47:0] addr_pool[8];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int find_row(input logic [47:0] addr);
        if (addr == '0) return -1;
        for (int i = 0; i < row_count; i++)
            if (table_rows[i].addr == addr) return i;
        return -1;
    endfunction

    // Updates the table copy and returns what the block should answer.
    function automatic t_answer apply_request(input t_request r);
        t_answer a;
        int pos;
        a = '0;
        if (r.cmd == ptlru_pkg::CMD_TOUCH) begin
            if (r.addr == '0) begin
                a.status = ptlru_pkg::ST_BADARG;
                return a;
            end
            pos = find_row(r.addr);
            if (pos < 0) begin
                if (row_count < SLOTS) begin
                    pos = row_count;
                    row_count++;
                end else begin
                    for (int i = 0; i < row_count; i++)
                        if (!table_rows[i].pinned &&
                            (pos < 0 || table_rows[i].time_stamp < table_rows[pos].time_stamp))
                            pos = i;
                    if (pos < 0) begin
                        a.status = ptlru_pkg::ST_FULL;
                        return a;
                    end
                end
                table_rows[pos] = '0;
                table_rows[pos].addr = r.addr;
            end
            table_rows[pos].time_stamp = r.now;
        end else begin
            pos = find_row(r.addr);
            if (pos < 0) begin
                a.status = ptlru_pkg::ST_NOTFOUND;
                return a;
            end
            if (r.cmd == ptlru_pkg::CMD_SET_REG) table_rows[pos].registered = r.flag;
            else if (r.cmd == ptlru_pkg::CMD_SET_PIN) table_rows[pos].pinned = r.flag;
            else if (r.cmd == ptlru_pkg::CMD_REMOVE) begin
                for (int i = pos; i + 1 < row_count; i++) table_rows[i] = table_rows[i + 1];
                table_rows[row_count - 1] = '0;
                row_count--;
                a.status = ptlru_pkg::ST_OK;
                a.index = pos[3:0];
                return a;
            end
        end
        a.status = ptlru_pkg::ST_OK;
        a.index = pos[3:0];
        a.registered = table_rows[pos].registered;
        a.pinned = table_rows[pos].pinned;
        a.last_used = table_rows[pos].time_stamp;
        return a;
    endfunction

    // Driver: presents queued requests at the falling edge; a request is held until
    // its transfer has been seen.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_done)) begin
            in_done = 1'b0;
            if (hold_sender && expected_answers.size() != 0) begin
                i_in_valid <= 1'b0;
            end else if (pending_requests.size() != 0 &&
                         $urandom_range(99, 0) >= send_idle_pct) begin
                t_request r;
                r = pending_requests.pop_front();
                hold_sender = 1'b0;
                i_cmd <= r.cmd;
                i_peer_address <= r.addr;
                i_now_time <= r.now;
                i_flag_value <= r.flag;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        if (i_rst_n) i_out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end

    // Monitor: predicts on each input transfer and checks each result transfer.
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            in_done = 1'b1;
            expected_answers.push_back(apply_request({i_cmd, i_peer_address, i_now_time,
                                                      i_flag_value}));
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_status), '0);
            end else begin
                t_answer w;
                w = expected_answers.pop_front();
                answers_checked++;
                if (o_status !== w.status)
                    report_mismatch("status", 32'(o_status), 32'(w.status));
                if (o_entry_index !== w.index)
                    report_mismatch("entry_index", 32'(o_entry_index), 32'(w.index));
                if (o_is_registered !== w.registered)
                    report_mismatch("is_registered", 32'(o_is_registered), 32'(w.registered));
                if (o_is_pinned !== w.pinned)
                    report_mismatch("is_pinned", 32'(o_is_pinned), 32'(w.pinned));
                if (o_last_used !== w.last_used)
                    report_mismatch("last_used", o_last_used, w.last_used);
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [47:0] pick_address();
        int k;
        k = $urandom_range(99, 0);
        if (k < 80) return addr_pool[$urandom_range(7, 0)];
        if (k < 85) return '0;
        if (k < 90) return '1;
        return 48'({$urandom, $urandom});
    endfunction

    task automatic add_request(input logic [2:0] cmd, input logic [47:0] addr,
                               input logic [31:0] now, input logic flag);
        t_request r;
        r.cmd = cmd;
        r.addr = addr;
        r.now = now;
        r.flag = flag;
        pending_requests.push_back(r);
    endtask

    task automatic add_random(input int count);
        int c;
        logic [2:0] cmd;
        for (int n = 0; n < count; n++) begin
            c = $urandom_range(99, 0);
            if (c < 45) cmd = ptlru_pkg::CMD_TOUCH;
            else if (c < 57) cmd = ptlru_pkg::CMD_LOOKUP;
            else if (c < 69) cmd = ptlru_pkg::CMD_SET_REG;
            else if (c < 82) cmd = ptlru_pkg::CMD_SET_PIN;
            else if (c < 96) cmd = ptlru_pkg::CMD_REMOVE;
            else cmd = 3'($urandom_range(7, 5));
            add_request(cmd, pick_address(), ($urandom_range(9, 0) == 0) ? '1 : $urandom,
                        1'($urandom_range(1, 0)));
        end
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || expected_answers.size() != 0 ||
               i_in_valid) @(posedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) table_rows[i] = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed: zero address on touch and lookup, extremes, filling to capacity,
        // LRU eviction with a tie, removal from the middle.
        add_request(ptlru_pkg::CMD_TOUCH, '0, 32'd5, 1'b0);
        add_request(ptlru_pkg::CMD_LOOKUP, '0, 32'd0, 1'b0);
        add_request(ptlru_pkg::CMD_REMOVE, 48'h1, 32'd0, 1'b0);
        add_request(ptlru_pkg::CMD_TOUCH, '1, '1, 1'b0);
        add_request(ptlru_pkg::CMD_SET_REG, '1, 32'd0, 1'b1);
        add_request(ptlru_pkg::CMD_SET_PIN, '1, 32'd0, 1'b1);
        add_request(3'd7, '1, 32'd0, 1'b0);
        for (int i = 1; i < SLOTS; i++)
            add_request(ptlru_pkg::CMD_TOUCH, 48'(i), 32'd100, 1'b0);
        add_request(ptlru_pkg::CMD_TOUCH, 48'h1234, 32'd1, 1'b0);
        add_request(ptlru_pkg::CMD_REMOVE, 48'd3, 32'd0, 1'b0);
        add_request(ptlru_pkg::CMD_LOOKUP, 48'd4, 32'd0, 1'b1);
        drain();
        for (int i = 1; i < SLOTS; i++)
            add_request(ptlru_pkg::CMD_SET_PIN, 48'(i), 32'd0, 1'b1);
        add_request(ptlru_pkg::CMD_SET_PIN, 48'h1234, 32'd0, 1'b1);
        add_request(ptlru_pkg::CMD_TOUCH, 48'h3, 32'd0, 1'b0);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 25 : phase == 1 ? 62 : 0;
            recv_idle_pct = phase == 0 ? 62 : phase == 1 ? 25 : 0;
            for (int blk = 0; blk < 5; blk++) begin
                for (int i = 0; i < 8; i++) addr_pool[i] = 48'({$urandom, $urandom});
                if (blk == 2) begin
                    // Fill the table with fresh addresses so replacement is exercised.
                    for (int i = 0; i < 8; i++)
                        add_request(ptlru_pkg::CMD_TOUCH, 48'({$urandom, $urandom}),
                                    $urandom_range(3, 0), 1'b0);
                end
                add_random(46);
                if (blk == 1) hold_sender = 1'b1;
            end
            drain();
            if (phase == 0) send_idle_pct = 0;
        end
        repeat (2 * SLOTS + 10) @(posedge i_clk);
        $display("Checked %0d results over directed and random table operations", answers_checked);
        $display("Covered fill, eviction, pinning, removal and zero addresses under stalls");
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+design
design/ptlru_pkg.sv
design/ptlru_cell.sv
design/peer_table_lru_replacement.sv
tb/sv/peer_table_lru_replacement_test.sv
